[design/rhc_pkg.sv]
package rhc_pkg;

  // Whole degrees of hue need nine bits (0 up to 359).
  localparam int HUE_INT_BITS = 9;
  localparam int DEG60 = 60;
  localparam int DEG360 = 360;

  // Hue numerator offsets, in units of 60 degrees.
  localparam int GREEN_BASE = 2;
  localparam int BLUE_BASE = 4;
  localparam int RED_WRAP = 6;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

[design/rgb_to_hsv_converter_top.sv]
// Channel  | Handshake          | Payload
// request  | start / busy       | in_red, in_green, in_blue
// result   | out_valid (strobe) | out_hue, out_sat, out_val
//
// One pixel is taken in every cycle; busy is always low.
// A result passes two setup stages, then one cell per quotient bit of the cell
// chain that the saturation and hue dividers share.
// Reset clears only the valid bits of the stages; there is no clearing pass.
// The receiver cannot stall; each result shows for exactly one cycle.
module rgb_to_hsv_converter_top import rhc_pkg::*; #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [CHANNEL_BITS-1:0]               in_red,
  input  logic [CHANNEL_BITS-1:0]               in_green,
  input  logic [CHANNEL_BITS-1:0]               in_blue,
  output logic                                  out_valid,
  output logic [HUE_INT_BITS+HUE_FRAC_BITS-1:0] out_hue,
  output logic [CHANNEL_BITS-1:0]               out_sat,
  output logic [CHANNEL_BITS-1:0]               out_val
);

  localparam int C = CHANNEL_BITS;
  localparam int HUE_BITS = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int QB = (C > HUE_BITS) ? C : HUE_BITS;
  localparam int RW = QB + C;

  logic          valid_c   [QB+1];
  logic [C-1:0]  val_c     [QB+1];
  logic [RW-1:0] sat_rem_c [QB+1];
  logic [C-1:0]  sat_div_c [QB+1];
  logic [QB-1:0] sat_q_c   [QB+1];
  logic [RW-1:0] hue_rem_c [QB+1];
  logic [C-1:0]  hue_div_c [QB+1];
  logic [QB-1:0] hue_q_c   [QB+1];

  assign busy = 1'b0;

  rhc_front #(
    .C  (C),
    .F  (HUE_FRAC_BITS),
    .RW (RW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (start & ~busy),
    .red_i     (in_red),
    .green_i   (in_green),
    .blue_i    (in_blue),
    .valid_o   (valid_c[0]),
    .val_o     (val_c[0]),
    .sat_rem_o (sat_rem_c[0]),
    .sat_div_o (sat_div_c[0]),
    .hue_rem_o (hue_rem_c[0]),
    .hue_div_o (hue_div_c[0])
  );

  assign sat_q_c[0] = '0;
  assign hue_q_c[0] = '0;

  // The first cell settles the top quotient bit.
  for (genvar k = 0; k < QB; k++) begin : g_cell
    rhc_cell #(
      .C   (C),
      .QB  (QB),
      .RW  (RW),
      .IDX (QB - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_i   (valid_c[k]),
      .val_i     (val_c[k]),
      .sat_rem_i (sat_rem_c[k]),
      .sat_div_i (sat_div_c[k]),
      .sat_q_i   (sat_q_c[k]),
      .hue_rem_i (hue_rem_c[k]),
      .hue_div_i (hue_div_c[k]),
      .hue_q_i   (hue_q_c[k]),
      .valid_o   (valid_c[k+1]),
      .val_o     (val_c[k+1]),
      .sat_rem_o (sat_rem_c[k+1]),
      .sat_div_o (sat_div_c[k+1]),
      .sat_q_o   (sat_q_c[k+1]),
      .hue_rem_o (hue_rem_c[k+1]),
      .hue_div_o (hue_div_c[k+1]),
      .hue_q_o   (hue_q_c[k+1])
    );
  end

  assign out_valid = valid_c[QB];
  assign out_val   = val_c[QB];
  assign out_sat   = sat_q_c[QB][C-1:0];
  assign out_hue   = hue_q_c[QB][HUE_BITS-1:0];

endmodule

[design/rhc_front.sv]
module rhc_front import rhc_pkg::*; #(
  parameter int C  = 8,
  parameter int F  = 6,
  parameter int RW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [C-1:0]  red_i,
  input  logic [C-1:0]  green_i,
  input  logic [C-1:0]  blue_i,
  output logic          valid_o,
  output logic [C-1:0]  val_o,
  output logic [RW-1:0] sat_rem_o,
  output logic [C-1:0]  sat_div_o,
  output logic [RW-1:0] hue_rem_o,
  output logic [C-1:0]  hue_div_o
);

  localparam int NW = C + 3;
  localparam logic [RW-1:0] HUE_SCALE = RW'(DEG60) << F;

  logic          s1_valid_r, s1_valid_nxt;
  logic [C-1:0]  s1_mx_r, s1_mx_nxt;
  logic [C-1:0]  s1_delta_r, s1_delta_nxt;
  logic [NW-1:0] s1_num_r, s1_num_nxt;

  logic          s2_valid_r;
  logic [C-1:0]  s2_val_r, s2_val_nxt;
  logic [RW-1:0] s2_sat_rem_r, s2_sat_rem_nxt;
  logic [C-1:0]  s2_sat_div_r, s2_sat_div_nxt;
  logic [RW-1:0] s2_hue_rem_r, s2_hue_rem_nxt;
  logic [C-1:0]  s2_hue_div_r, s2_hue_div_nxt;

  logic [C-1:0]  mn;
  logic [NW-1:0] re, ge, be, de;
  sector_t       sector;

  // First stage: extremes, sector and a non-negative hue numerator in units of
  // 60 degrees over delta.
  always_comb begin
    s1_valid_nxt = valid_i;
    s1_mx_nxt = red_i;
    mn = red_i;
    if (green_i > s1_mx_nxt) s1_mx_nxt = green_i;
    if (blue_i > s1_mx_nxt) s1_mx_nxt = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    s1_delta_nxt = s1_mx_nxt - mn;

    if (red_i == s1_mx_nxt) begin
      sector = SEC_RED;
    end else if (green_i == s1_mx_nxt) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end

    re = NW'(red_i);
    ge = NW'(green_i);
    be = NW'(blue_i);
    de = NW'(s1_delta_nxt);
    case (sector)
      SEC_RED: begin
        if (green_i >= blue_i) begin
          s1_num_nxt = ge - be;
        end else begin
          // A negative red-sector hue wraps around by a full turn.
          s1_num_nxt = NW'(RED_WRAP) * de - (be - ge);
        end
      end
      SEC_GREEN: s1_num_nxt = (NW'(GREEN_BASE) * de + be) - re;
      SEC_BLUE:  s1_num_nxt = (NW'(BLUE_BASE) * de + re) - ge;
      default:   s1_num_nxt = '0;
    endcase
  end

  // Second stage: scale both dividends. Gray and black get a unit divisor so
  // the zero dividends give zero quotients.
  always_comb begin
    s2_val_nxt = s1_mx_r;
    s2_sat_rem_nxt = (RW'(s1_delta_r) << C) - RW'(s1_delta_r);
    s2_hue_rem_nxt = RW'(s1_num_r) * HUE_SCALE;
    if (s1_delta_r == '0) begin
      s2_sat_div_nxt = C'(1);
      s2_hue_div_nxt = C'(1);
    end else begin
      s2_sat_div_nxt = s1_mx_r;
      s2_hue_div_nxt = s1_delta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r      <= s1_mx_nxt;
    s1_delta_r   <= s1_delta_nxt;
    s1_num_r     <= s1_num_nxt;
    s2_val_r     <= s2_val_nxt;
    s2_sat_rem_r <= s2_sat_rem_nxt;
    s2_sat_div_r <= s2_sat_div_nxt;
    s2_hue_rem_r <= s2_hue_rem_nxt;
    s2_hue_div_r <= s2_hue_div_nxt;
  end

  assign valid_o   = s2_valid_r;
  assign val_o     = s2_val_r;
  assign sat_rem_o = s2_sat_rem_r;
  assign sat_div_o = s2_sat_div_r;
  assign hue_rem_o = s2_hue_rem_r;
  assign hue_div_o = s2_hue_div_r;

endmodule

[design/rhc_cell.sv]
module rhc_cell import rhc_pkg::*; #(
  parameter int C   = 8,
  parameter int QB  = 15,
  parameter int RW  = 23,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [C-1:0]  val_i,
  input  logic [RW-1:0] sat_rem_i,
  input  logic [C-1:0]  sat_div_i,
  input  logic [QB-1:0] sat_q_i,
  input  logic [RW-1:0] hue_rem_i,
  input  logic [C-1:0]  hue_div_i,
  input  logic [QB-1:0] hue_q_i,
  output logic          valid_o,
  output logic [C-1:0]  val_o,
  output logic [RW-1:0] sat_rem_o,
  output logic [C-1:0]  sat_div_o,
  output logic [QB-1:0] sat_q_o,
  output logic [RW-1:0] hue_rem_o,
  output logic [C-1:0]  hue_div_o,
  output logic [QB-1:0] hue_q_o
);

  logic          valid_r;
  logic [C-1:0]  val_r;
  logic [RW-1:0] sat_rem_r, sat_rem_nxt;
  logic [C-1:0]  sat_div_r;
  logic [QB-1:0] sat_q_r, sat_q_nxt;
  logic [RW-1:0] hue_rem_r, hue_rem_nxt;
  logic [C-1:0]  hue_div_r;
  logic [QB-1:0] hue_q_r, hue_q_nxt;

  logic [RW-1:0] sat_shift, hue_shift;
  logic          sat_take, hue_take;

  // One restoring step per divider: this cell decides quotient bit IDX.
  always_comb begin
    sat_shift   = RW'(sat_div_i) << IDX;
    hue_shift   = RW'(hue_div_i) << IDX;
    sat_take    = sat_rem_i >= sat_shift;
    hue_take    = hue_rem_i >= hue_shift;
    sat_rem_nxt = sat_take ? sat_rem_i - sat_shift : sat_rem_i;
    hue_rem_nxt = hue_take ? hue_rem_i - hue_shift : hue_rem_i;
    sat_q_nxt   = sat_q_i | (QB'(sat_take) << IDX);
    hue_q_nxt   = hue_q_i | (QB'(hue_take) << IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_i;
    sat_rem_r <= sat_rem_nxt;
    sat_div_r <= sat_div_i;
    sat_q_r   <= sat_q_nxt;
    hue_rem_r <= hue_rem_nxt;
    hue_div_r <= hue_div_i;
    hue_q_r   <= hue_q_nxt;
  end

  assign valid_o   = valid_r;
  assign val_o     = val_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign sat_q_o   = sat_q_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign hue_q_o   = hue_q_r;

endmodule

[design/rhc_checker.sv]
module rhc_checker import rhc_pkg::*; #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic [CHANNEL_BITS-1:0]               in_red,
  input logic [CHANNEL_BITS-1:0]               in_green,
  input logic [CHANNEL_BITS-1:0]               in_blue,
  input logic                                  out_valid,
  input logic [HUE_INT_BITS+HUE_FRAC_BITS-1:0] out_hue,
  input logic [CHANNEL_BITS-1:0]               out_sat,
  input logic [CHANNEL_BITS-1:0]               out_val
);

  localparam int HUE_BITS = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int QB = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;
  localparam int LAT = QB + 2;
  localparam logic [HUE_BITS:0] HUE_TURN = (HUE_BITS + 1)'(DEG360) << HUE_FRAC_BITS;

  logic [CHANNEL_BITS-1:0] in_max;

  always_comb begin
    in_max = in_red;
    if (in_green > in_max) in_max = in_green;
    if (in_blue > in_max) in_max = in_blue;
  end

  // Every result stems from a request that was taken while busy was low.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_val == $past(in_max, LAT))
    else $error("value is not the largest channel of its request");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_hue} < HUE_TURN)
    else $error("hue reaches a full turn");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_val == '0 |-> out_hue == '0 && out_sat == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat == '0 && out_val != '0 |-> out_hue == '0)
    else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_top rhc_checker #(
  .CHANNEL_BITS  (CHANNEL_BITS),
  .HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_rhc_checker (.*);
